### design/salru_pkg.sv
// Shared constants and width helpers for the set-associative LRU lookup block.
// Used by salru_front, salru_back and set_assoc_cache_lru_lookup; no dependencies.

package salru_pkg;

   // Default geometry
   localparam int WAYS_DEF       = 8;
   localparam int SETS_DEF       = 64;
   localparam int LINE_BYTES_DEF = 64;
   localparam int ADDR_BITS_DEF  = 32;

   // Stream word widths
   localparam int REQ_TDATA_W = 32;
   localparam int WAY_OUT_W   = 3;
   localparam int TOTAL_W     = 32;
   localparam int RSP_BITS    = 1 + WAY_OUT_W + 1 + TOTAL_W + TOTAL_W;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   // Address split queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Address bits actually looked at
   function automatic int eff_bits(input int addr_bits);
      int r;
      r = (addr_bits < REQ_TDATA_W) ? addr_bits : REQ_TDATA_W;
      return r;
   endfunction

   // Set index width (at least one bit so ports stay legal)
   function automatic int set_width(input int sets);
      int r;
      r = (sets > 1) ? $clog2(sets) : 1;
      return r;
   endfunction

   // Tag width (at least one bit; tag reads as zero when no bits remain)
   function automatic int tag_width(input int sets, input int line_bytes, input int addr_bits);
      int r;
      r = eff_bits(addr_bits) - $clog2(line_bytes) - $clog2(sets);
      if (r < 1) begin
         r = 1;
      end
      return r;
   endfunction

endpackage

### design/salru_front.sv
// Front end: accepts address words, splits them into set index and tag, and
// queues them for the back end. Depends on salru_pkg.

module salru_front #(
   parameter int SETS       = salru_pkg::SETS_DEF,
   parameter int LINE_BYTES = salru_pkg::LINE_BYTES_DEF,
   parameter int ADDR_BITS  = salru_pkg::ADDR_BITS_DEF,
   localparam int SET_W     = salru_pkg::set_width(SETS),
   localparam int TAG_W     = salru_pkg::tag_width(SETS, LINE_BYTES, ADDR_BITS)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [salru_pkg::REQ_TDATA_W-1:0]  req_tdata,   // [31:0] address
   input  logic                               hold,
   output logic                               q_valid,
   input  logic                               q_ready,
   output logic [SET_W-1:0]                   q_set,
   output logic [TAG_W-1:0]                   q_tag
);

   localparam int OFF_BITS  = $clog2(LINE_BYTES);
   localparam int TAG_SHIFT = OFF_BITS + $clog2(SETS);
   localparam int EFF_BITS  = salru_pkg::eff_bits(ADDR_BITS);
   localparam logic [salru_pkg::REQ_TDATA_W-1:0] ADDR_MASK =
      salru_pkg::REQ_TDATA_W'((64'd1 << EFF_BITS) - 64'd1);
   localparam logic [SET_W-1:0] SET_MASK = SET_W'(SETS - 1);
   localparam int CNT_W = $clog2(salru_pkg::QUEUE_DEPTH + 1);
   localparam int PTR_W = $clog2(salru_pkg::QUEUE_DEPTH);

   logic [salru_pkg::REQ_TDATA_W-1:0] addr_m;
   logic [SET_W-1:0] set_idx;
   logic [TAG_W-1:0] tag_val;
   logic             push;
   logic             pop;

   logic [SET_W-1:0] set_q_ff [salru_pkg::QUEUE_DEPTH];
   logic [TAG_W-1:0] tag_q_ff [salru_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // Address split
   always_comb begin
      addr_m  = req_tdata & ADDR_MASK;
      set_idx = SET_W'(addr_m >> OFF_BITS) & SET_MASK;
      tag_val = TAG_W'(addr_m >> TAG_SHIFT);
   end

   // Queue handshake
   assign req_tready = !hold && (cnt_ff != CNT_W'(salru_pkg::QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (cnt_ff != '0);
   assign pop        = q_valid && q_ready;
   assign q_set      = set_q_ff[rd_ptr_ff];
   assign q_tag      = tag_q_ff[rd_ptr_ff];

   // Pointer and fill count next values
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(salru_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(salru_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Queue payload
   always_ff @(posedge clock) begin
      if (push) begin
         set_q_ff[wr_ptr_ff] <= set_idx;
         tag_q_ff[wr_ptr_ff] <= tag_val;
      end
   end

endmodule

### design/salru_back.sv
// Back end: set memory, tag compare across ways, LRU age update, hit/miss
// totals and the result output register. Depends on salru_pkg.

module salru_back #(
   parameter int WAYS       = salru_pkg::WAYS_DEF,
   parameter int SETS       = salru_pkg::SETS_DEF,
   parameter int LINE_BYTES = salru_pkg::LINE_BYTES_DEF,
   parameter int ADDR_BITS  = salru_pkg::ADDR_BITS_DEF,
   localparam int SET_W     = salru_pkg::set_width(SETS),
   localparam int TAG_W     = salru_pkg::tag_width(SETS, LINE_BYTES, ADDR_BITS)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               q_valid,
   output logic                               q_ready,
   input  logic [SET_W-1:0]                   q_set,
   input  logic [TAG_W-1:0]                   q_tag,
   output logic                               busy,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [salru_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   localparam int AGE_W = $clog2(WAYS);
   localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(WAYS - 1);

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_UPDATE = 2'd2;

   typedef struct packed {
      logic             v;
      logic [AGE_W-1:0] age;
      logic [TAG_W-1:0] tag;
   } line_type;

   typedef line_type [WAYS-1:0] row_type;

   // One row per set holds all ways
   row_type mem [SETS];

   logic [1:0]       state_ff, state_in;
   logic [SET_W-1:0] clr_ff, clr_in;
   logic [SET_W-1:0] set_ff;
   logic [TAG_W-1:0] tag_ff;
   row_type          row_rd_ff;
   logic             rd_en;
   logic             wr_en;
   logic [SET_W-1:0] wr_addr;
   row_type          wr_row;
   row_type          new_row;
   logic             out_free;
   logic             do_update;

   logic [WAYS-1:0]  match;
   logic [WAYS-1:0]  invalid;
   logic [WAYS-1:0]  oldest;
   logic             hit;
   logic             full;
   logic [AGE_W-1:0] hit_way;
   logic [AGE_W-1:0] empty_way;
   logic [AGE_W-1:0] victim_way;
   logic [AGE_W-1:0] way_sel;
   logic [AGE_W-1:0] limit;

   logic [salru_pkg::TOTAL_W-1:0] hit_cnt_ff, hit_cnt_in;
   logic [salru_pkg::TOTAL_W-1:0] miss_cnt_ff, miss_cnt_in;
   logic                               rsp_valid_ff;
   logic [salru_pkg::RSP_TDATA_W-1:0]  rsp_data_ff, rsp_data_in;

   assign busy      = (state_ff == ST_CLEAR);
   assign q_ready   = (state_ff == ST_IDLE);
   assign rd_en     = q_valid && q_ready;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign do_update = (state_ff == ST_UPDATE) && out_free;

   // Sequencer: clearing sweep, then read / update per word
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == SET_W'(SETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (rd_en) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (do_update) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   // Tag and set of the word in flight
   always_ff @(posedge clock) begin
      if (rd_en) begin
         set_ff <= q_set;
         tag_ff <= q_tag;
      end
   end

   // Set memory, registered read
   assign wr_en   = busy || do_update;
   assign wr_addr = busy ? clr_ff : set_ff;
   assign wr_row  = busy ? '0 : new_row;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_row;
      end
      if (rd_en) begin
         row_rd_ff <= mem[q_set];
      end
   end

   // Per-way compare, empty and oldest flags
   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         match[w]   = row_rd_ff[w].v && (row_rd_ff[w].tag == tag_ff);
         invalid[w] = !row_rd_ff[w].v;
         oldest[w]  = 1'b1;
         for (int u = 0; u < WAYS; u++) begin
            if (u < w) begin
               if (!(row_rd_ff[w].age > row_rd_ff[u].age)) begin
                  oldest[w] = 1'b0;
               end
            end else if (u > w) begin
               if (row_rd_ff[w].age < row_rd_ff[u].age) begin
                  oldest[w] = 1'b0;
               end
            end
         end
      end
   end

   // Way selection
   always_comb begin
      hit        = |match;
      full       = ~|invalid;
      hit_way    = '0;
      empty_way  = '0;
      victim_way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (match[w]) begin
            hit_way = AGE_W'(w);
         end
         if (invalid[w]) begin
            empty_way = AGE_W'(w);
         end
      end
      for (int w = 0; w < WAYS; w++) begin
         if (oldest[w]) begin
            victim_way = victim_way | AGE_W'(w);
         end
      end
      if (hit) begin
         way_sel = hit_way;
         limit   = row_rd_ff[hit_way].age;
      end else begin
         way_sel = full ? victim_way : empty_way;
         limit   = AGE_MAX;
      end
   end

   // Updated row: age the others, refresh the chosen way
   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         new_row[w] = row_rd_ff[w];
         if (AGE_W'(w) == way_sel) begin
            new_row[w].v   = 1'b1;
            new_row[w].tag = tag_ff;
            new_row[w].age = '0;
         end else if (row_rd_ff[w].v && (row_rd_ff[w].age < limit)) begin
            new_row[w].age = row_rd_ff[w].age + 1'b1;
         end
      end
   end

   // Totals and result word
   always_comb begin
      hit_cnt_in  = hit_cnt_ff + salru_pkg::TOTAL_W'(hit);
      miss_cnt_in = miss_cnt_ff + salru_pkg::TOTAL_W'(!hit);
      rsp_data_in = salru_pkg::RSP_TDATA_W'({miss_cnt_in, hit_cnt_in, (!hit && !full),
                                             salru_pkg::WAY_OUT_W'(way_sel), hit});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (do_update) begin
         hit_cnt_ff   <= hit_cnt_in;
         miss_cnt_ff  <= miss_cnt_in;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (do_update) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### design/set_assoc_cache_lru_lookup.sv
// Set-associative cache lookup with true-LRU age counters.
// req_ channel: one 32-bit byte address per word. It is split into line
// offset, set index and tag (SETS and LINE_BYTES are powers of two), then
// queued in a two-word queue ahead of the lookup engine.
// rsp_ channel: one result word per address: hit, way used, filled-empty
// flag and the running hit and miss totals after that access.
// Timing: the engine reads the set memory for a word, then in its update
// state does compare, age update and write-back of the whole set row; it
// takes no new word from the queue until that update is done. A word passes
// the queue, the set memory read register and the output register.
// Reset: synchronous, active high. After reset the engine sweeps the set
// memory, one set per cycle, through every set; req_tready stays low meanwhile.
// Totals, tags, valid marks and ages all start at zero.
// Stall: rsp_ words sit in an output register; while it is full and not
// taken the engine holds its finished word, and the queue keeps accepting
// addresses until it holds two.
// Depends on salru_pkg, salru_front and salru_back.

module set_assoc_cache_lru_lookup #(
   parameter int WAYS       = salru_pkg::WAYS_DEF,
   parameter int SETS       = salru_pkg::SETS_DEF,
   parameter int LINE_BYTES = salru_pkg::LINE_BYTES_DEF,
   parameter int ADDR_BITS  = salru_pkg::ADDR_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [salru_pkg::REQ_TDATA_W-1:0]  req_tdata,  // [31:0] address
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [0] hit, [3:1] way_used, [4] filled_empty, [36:5] hit_total,
   // [68:37] miss_total, [71:69] zero
   output logic [salru_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   localparam int SET_W = salru_pkg::set_width(SETS);
   localparam int TAG_W = salru_pkg::tag_width(SETS, LINE_BYTES, ADDR_BITS);

   logic             q_valid;
   logic             q_ready;
   logic [SET_W-1:0] q_set;
   logic [TAG_W-1:0] q_tag;
   logic             busy;

   salru_front #(
      .SETS       (SETS),
      .LINE_BYTES (LINE_BYTES),
      .ADDR_BITS  (ADDR_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .hold       (busy),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_set      (q_set),
      .q_tag      (q_tag)
   );

   salru_back #(
      .WAYS       (WAYS),
      .SETS       (SETS),
      .LINE_BYTES (LINE_BYTES),
      .ADDR_BITS  (ADDR_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_set      (q_set),
      .q_tag      (q_tag),
      .busy       (busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
